// File: src/csrm_pkg.sv
// ----------------------------------------------------------------------------
// csrm_pkg
// Shared types and constants for the compressed-sparse-row matrix store.
// ----------------------------------------------------------------------------
package csrm_pkg;

    localparam int MAX_DIM    = 256;
    localparam int CAPACITY   = 1024;
    localparam int VALUE_BITS = 32;

    localparam int DIM_W   = $clog2(MAX_DIM);        // row / column index
    localparam int DIMC_W  = $clog2(MAX_DIM + 1);    // dimension incl. MAX_DIM
    localparam int ADDR_W  = $clog2(CAPACITY);       // entry address
    localparam int CNT_W   = $clog2(CAPACITY + 1);   // entry count / pointer
    localparam int RPTR_W  = $clog2(MAX_DIM + 1);    // pointer array address

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    localparam logic OP_READ   = 1'b0;
    localparam logic OP_MODIFY = 1'b1;

    localparam int CFG_ROW_COUNT    = 0;
    localparam int CFG_COLUMN_COUNT = 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PTR_LO,
        S_PTR_HI,
        S_SCAN_REQ,
        S_SCAN,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_DEL_RD,
        S_DEL_WR,
        S_PTR_RD,
        S_PTR_WR,
        S_DONE
    } state_t;

endpackage

// File: src/csr_sparse_matrix_store.sv
// A read fetches the two row pointers, then scans the row from its first entry and
// stops at the matching column, at a larger column or at the end of the row; an
// out-of-range access goes straight to the result. Insert/removal also shift every
// later entry and rewrite every row pointer above the row, up to the last pointer.
// One transaction at a time.
// Reset: empty matrix, row_count and column_count 256; memories need no clearing.
// ----------------------------------------------------------------------------
// csr_sparse_matrix_store
// Sparse matrix in CSR form with element read and modify (overwrite, sorted
// insert, removal) sequenced over a pointer memory and an entry memory.
// ----------------------------------------------------------------------------
module csr_sparse_matrix_store (
    input  logic                               clk,
    input  logic                               rst_n,
    // input transactions
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               operation,
    input  logic [7:0]                         row,
    input  logic [7:0]                         column,
    input  logic signed [31:0]                 new_value,
    // result transactions
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [31:0]                 old_value,
    output logic [1:0]                         status,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [0:0]                         cfg_index,
    input  logic [8:0]                         cfg_data
);
    import csrm_pkg::*;

    localparam int EW = DIM_W + VALUE_BITS;

    // storage
    logic [CNT_W-1:0] ptr_mem [0:MAX_DIM];
    logic [EW-1:0]    ent_mem [0:CAPACITY-1];

    // registers
    state_t              state_reg, state_next;
    logic [8:0]          rows_reg, rows_next, cols_reg, cols_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                op_reg, op_next;
    logic [DIM_W-1:0]    r_reg, r_next, c_reg, c_next;
    logic [VALUE_BITS-1:0] nv_reg, nv_next;
    logic [CNT_W-1:0]    lo_reg, lo_next, hi_reg, hi_next;
    logic [CNT_W-1:0]    pos_reg, pos_next, k_reg, k_next;
    logic [RPTR_W-1:0]   pk_reg, pk_next;
    logic                ins_reg, ins_next;
    logic                ov_reg, ov_next;
    logic [31:0]         old_reg, old_next;
    status_t             st_reg, st_next;

    // memory ports
    logic                p_we;
    logic [RPTR_W-1:0]   p_addr;
    logic [CNT_W-1:0]    p_wdata, p_rdata;
    logic                e_we;
    logic [ADDR_W-1:0]   e_addr;
    logic [EW-1:0]       e_wdata, e_rdata;

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            ptr_mem[p_addr] <= p_wdata;
        end
        p_rdata <= ptr_mem[p_addr];
    end

    always_ff @(posedge clk)
    begin
        if (e_we)
        begin
            ent_mem[e_addr] <= e_wdata;
        end
        e_rdata <= ent_mem[e_addr];
    end

    // pointer memory has valid-less reset: track which words were written
    logic [MAX_DIM:0] pval_reg, pval_next;

    logic [CNT_W-1:0] p_rd;
    assign p_rd = pval_reg[pk_reg] ? p_rdata : '0;

    // clamped dimensions
    logic [DIMC_W-1:0] rlim, clim;
    assign rlim = (rows_reg > 9'(MAX_DIM)) ? DIMC_W'(MAX_DIM) : DIMC_W'(rows_reg);
    assign clim = (cols_reg > 9'(MAX_DIM)) ? DIMC_W'(MAX_DIM) : DIMC_W'(cols_reg);

    logic in_acc;
    assign in_acc   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !ov_reg;

    logic [DIM_W-1:0]      e_col;
    logic [VALUE_BITS-1:0] e_val;
    assign e_col = e_rdata[EW-1:VALUE_BITS];
    assign e_val = e_rdata[VALUE_BITS-1:0];

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rows_reg  <= 9'(MAX_DIM);
            cols_reg  <= 9'(MAX_DIM);
            count_reg <= '0;
            ov_reg    <= 1'b0;
            pval_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rows_reg  <= rows_next;
            cols_reg  <= cols_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
            pval_reg  <= pval_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        r_reg   <= r_next;
        c_reg   <= c_next;
        nv_reg  <= nv_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        pos_reg <= pos_next;
        k_reg   <= k_next;
        pk_reg  <= pk_next;
        ins_reg <= ins_next;
        old_reg <= old_next;
        st_reg  <= st_next;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        rows_next  = rows_reg;
        cols_next  = cols_reg;
        count_next = count_reg;
        ov_next    = ov_reg;
        pval_next  = pval_reg;
        op_next    = op_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        nv_next    = nv_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        pos_next   = pos_reg;
        k_next     = k_reg;
        pk_next    = pk_reg;
        ins_next   = ins_reg;
        old_next   = old_reg;
        st_next    = st_reg;
        p_we       = 1'b0;
        p_addr     = pk_reg;
        p_wdata    = '0;
        e_we       = 1'b0;
        e_addr     = k_reg[ADDR_W-1:0];
        e_wdata    = '0;

        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid && cfg_ready)
                begin
                    if (cfg_index == 1'(CFG_ROW_COUNT))
                    begin
                        rows_next = cfg_data;
                    end
                    else
                    begin
                        cols_next = cfg_data;
                    end
                end
                if (in_acc)
                begin
                    op_next  = operation;
                    r_next   = row;
                    c_next   = column;
                    nv_next  = VALUE_BITS'(new_value);
                    old_next = '0;
                    st_next  = ST_OK;
                    if ({1'b0, row} >= rlim || {1'b0, column} >= clim)
                    begin
                        st_next    = ST_RANGE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        pk_next    = RPTR_W'(row);
                        p_addr     = RPTR_W'(row);
                        state_next = S_PTR_LO;
                    end
                end
            end
            S_PTR_LO:
            begin
                lo_next    = p_rd;
                pk_next    = RPTR_W'(r_reg) + RPTR_W'(1);
                p_addr     = RPTR_W'(r_reg) + RPTR_W'(1);
                state_next = S_PTR_HI;
            end
            S_PTR_HI:
            begin
                hi_next = (p_rd > count_reg) ? count_reg : p_rd;
                if (lo_reg > hi_next)
                begin
                    lo_next = hi_next;
                end
                pos_next   = (lo_reg > hi_next) ? hi_next : lo_reg;
                state_next = S_SCAN_REQ;
            end
            S_SCAN_REQ:
            begin
                if (pos_reg < hi_reg)
                begin
                    e_addr     = pos_reg[ADDR_W-1:0];
                    state_next = S_SCAN;
                end
                else
                begin
                    ins_next   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (pos_reg < hi_reg && e_col < c_reg)
                begin
                    pos_next   = pos_reg + CNT_W'(1);
                    e_addr     = pos_next[ADDR_W-1:0];
                    state_next = (pos_next < hi_reg) ? S_SCAN : S_SCAN_REQ;
                    ins_next   = 1'b0;
                end
                else if (pos_reg < hi_reg && e_col == c_reg)
                begin
                    // element present
                    old_next = 32'(signed'(e_val));
                    if (op_reg == OP_READ)
                    begin
                        state_next = S_DONE;
                    end
                    else if (nv_reg != '0)
                    begin
                        e_we       = 1'b1;
                        e_addr     = pos_reg[ADDR_W-1:0];
                        e_wdata    = {c_reg, nv_reg};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ins_next   = 1'b0;
                        k_next     = pos_reg;
                        state_next = S_DEL_RD;
                    end
                end
                else
                begin
                    // element absent
                    if (op_reg == OP_READ || nv_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else if (count_reg >= CNT_W'(CAPACITY))
                    begin
                        st_next    = ST_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ins_next   = 1'b1;
                        k_next     = count_reg;
                        state_next = S_INS_RD;
                    end
                end
            end
            S_INS_RD:
            begin
                if (k_reg > pos_reg)
                begin
                    e_addr     = ADDR_W'(k_reg - CNT_W'(1));
                    state_next = S_INS_WR;
                end
                else
                begin
                    state_next = S_INS_PUT;
                end
            end
            S_INS_WR:
            begin
                e_we       = 1'b1;
                e_addr     = k_reg[ADDR_W-1:0];
                e_wdata    = e_rdata;
                k_next     = k_reg - CNT_W'(1);
                state_next = S_INS_RD;
            end
            S_INS_PUT:
            begin
                e_we       = 1'b1;
                e_addr     = pos_reg[ADDR_W-1:0];
                e_wdata    = {c_reg, nv_reg};
                count_next = count_reg + CNT_W'(1);
                pk_next    = RPTR_W'(r_reg) + RPTR_W'(1);
                p_addr     = RPTR_W'(r_reg) + RPTR_W'(1);
                state_next = S_PTR_RD;
            end
            S_DEL_RD:
            begin
                if (k_reg + CNT_W'(1) < count_reg)
                begin
                    e_addr     = ADDR_W'(k_reg + CNT_W'(1));
                    state_next = S_DEL_WR;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    pk_next    = RPTR_W'(r_reg) + RPTR_W'(1);
                    p_addr     = RPTR_W'(r_reg) + RPTR_W'(1);
                    state_next = S_PTR_RD;
                end
            end
            S_DEL_WR:
            begin
                e_we       = 1'b1;
                e_addr     = k_reg[ADDR_W-1:0];
                e_wdata    = e_rdata;
                k_next     = k_reg + CNT_W'(1);
                state_next = S_DEL_RD;
            end
            S_PTR_RD:
            begin
                // read of pk_reg issued last cycle; write adjusted word
                p_we    = 1'b1;
                p_addr  = pk_reg;
                p_wdata = ins_reg ? p_rd + CNT_W'(1)
                        : ((p_rd != '0) ? p_rd - CNT_W'(1) : p_rd);
                pval_next[pk_reg] = 1'b1;
                state_next = S_PTR_WR;
            end
            S_PTR_WR:
            begin
                if (pk_reg == RPTR_W'(MAX_DIM))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    pk_next    = pk_reg + RPTR_W'(1);
                    p_addr     = pk_reg + RPTR_W'(1);
                    state_next = S_PTR_RD;
                end
            end
            S_DONE:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result register (held until taken)
    logic [31:0] res_val_reg;
    status_t     res_st_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && (!ov_reg || !out_stall))
        begin
            res_val_reg <= old_reg;
            res_st_reg  <= st_reg;
        end
    end

    assign out_valid = ov_reg;
    assign old_value = signed'(res_val_reg);
    assign status    = res_st_reg;

endmodule
